// ----- rtl/core/ptbl_pkg.sv -----
// Shared types and constants for the per-client token bucket limiter.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package ptbl_pkg;

  // Q16.16 token arithmetic
  localparam logic [31:0] ONE_TOKEN    = 32'h0001_0000;
  localparam logic [23:0] RATE_DEFAULT = 24'h01_0000;
  localparam logic [15:0] BURST_DEFAULT = 16'd1;

  localparam int unsigned IN_W  = 64;  // client_address, current_time
  localparam int unsigned OUT_W = 24;  // allowed, new_client, table_full, tokens_left

  // Register map (word index)
  localparam logic REG_REFILL = 1'b0;
  localparam logic REG_BURST  = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] tokens;
    logic [31:0] last_time;
  } entry_t;

  typedef struct packed {
    logic load;        // latch request
    logic scan_start;  // read entry 0
    logic scan_step;   // advance scan index
    logic take_hit;    // latch matching entry
    logic mul;         // elapsed * rate
    logic add;         // refill, take token, form result
    logic fin;         // write back entry
    logic out_load;    // move result to output register
  } ptbl_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic match;
    logic scan_last;
    logic out_free;
  } ptbl_status_t;

endpackage

// ----- rtl/core/ptbl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptbl_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ptbl_ctrl.sv -----
// Sequencing state machine: handshake, table scan, refill and write back.
// Depends on ptbl_pkg.
`timescale 1ns / 1ps

module ptbl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ptbl_pkg::ptbl_status_t status_i,
  output ptbl_pkg::ptbl_cmd_t    cmd_o
);
  import ptbl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SCAN = 6'b000100,
    S_MUL  = 6'b001000,
    S_ADD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // empty table: straight to allocation
          state_d = status_i.fill_zero ? S_ADD : S_READ;
        end
      end
      S_READ: begin
        cmd_o.scan_start = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.match) begin
          cmd_o.take_hit = 1'b1;
          state_d = S_MUL;
        end else if (status_i.scan_last) begin
          state_d = S_ADD;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/ptbl_datapath.sv -----
// Bucket table, scan compare, refill multiply/add and result register.
// Depends on ptbl_pkg and ptbl_ram.
`timescale 1ns / 1ps

module ptbl_datapath #(
  parameter int unsigned CLIENT_ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ptbl_pkg::IN_W-1:0]  in_data_i,
  input  logic [23:0]                rate_i,
  input  logic [15:0]                burst_i,
  input  ptbl_pkg::ptbl_cmd_t        cmd_i,
  output ptbl_pkg::ptbl_status_t     status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ptbl_pkg::OUT_W-1:0] out_data_o
);
  import ptbl_pkg::*;

  localparam int unsigned IDX_W  = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(CLIENT_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CLIENT_ENTRIES);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(CLIENT_ENTRIES - 1);
  localparam int unsigned PROD_W = 56;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // request
  logic [31:0] key_q, now_q;
  // scan and allocation
  logic [IDX_W-1:0]  idx_q, slot_q;
  logic [FILL_W-1:0] fill_q;
  logic              hit_q;
  // bucket arithmetic
  logic [31:0]       tok_q, last_q;
  logic [PROD_W-1:0] prod_q;
  logic              nz_q;
  // result
  logic        allowed_q, fresh_q, full_q;
  logic [31:0] left_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  entry_t            rd_entry, wr_entry;
  logic [IDX_W-1:0]  raddr;
  logic              we;

  logic [23:0]       rate_eff;
  logic [31:0]       cap;
  logic [31:0]       elapsed;
  logic [PROD_W-1:0] prod_d;
  logic [SUM_W-1:0]  sum;
  logic [31:0]       refill_tok;

  assign rate_eff = (rate_i == 24'd0) ? RATE_DEFAULT : rate_i;
  assign cap      = {((burst_i == 16'd0) ? BURST_DEFAULT : burst_i), 16'h0000};

  // read one entry ahead of the compare
  assign raddr = cmd_i.scan_start ? '0 :
                 ((idx_q == IDX_LAST) ? idx_q : idx_q + IDX_W'(1));

  assign we       = cmd_i.fin && (hit_q || fresh_q);
  assign wr_entry = '{address: key_q, tokens: left_q, last_time: now_q};

  ptbl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CLIENT_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  assign elapsed = now_q - last_q;
  assign prod_d  = PROD_W'(elapsed) * PROD_W'(rate_eff);
  assign sum     = SUM_W'(tok_q) + SUM_W'(prod_q);
  assign refill_tok = !nz_q ? tok_q :
                      ((sum > SUM_W'(cap)) ? cap : sum[31:0]);

  assign status_o.fill_zero = (fill_q == '0);
  assign status_o.match     = (rd_entry.address == key_q);
  assign status_o.scan_last = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_data_i[31:0];
      now_q <= in_data_i[63:32];
    end
    if (cmd_i.take_hit) begin
      slot_q <= idx_q;
      tok_q  <= rd_entry.tokens;
      last_q <= rd_entry.last_time;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      nz_q   <= (elapsed != 32'd0);
    end
    if (cmd_i.add) begin
      if (hit_q) begin
        allowed_q <= (refill_tok >= ONE_TOKEN);
        left_q    <= (refill_tok >= ONE_TOKEN) ? refill_tok - ONE_TOKEN : refill_tok;
        fresh_q   <= 1'b0;
        full_q    <= 1'b0;
      end else if (fill_q == FILL_MAX) begin
        allowed_q <= 1'b1;
        left_q    <= '0;
        fresh_q   <= 1'b0;
        full_q    <= 1'b1;
      end else begin
        // fresh bucket starts full and gives up one token at once
        allowed_q <= 1'b1;
        left_q    <= cap - ONE_TOKEN;
        fresh_q   <= 1'b1;
        full_q    <= 1'b0;
        slot_q    <= IDX_W'(fill_q);
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= OUT_W'({left_q[31:16], full_q, fresh_q, allowed_q});
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      fill_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.take_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        if (fresh_q) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/per_client_token_bucket_limiter_core.sv -----
// Top level of the per-client token bucket limiter: APB registers, stream ports.
// Depends on ptbl_pkg, ptbl_ctrl, ptbl_datapath (and ptbl_ram below it).
//
//   channel   direction  handshake                  payload
//   s_axis    in         tvalid/tready              tdata[31:0] address, [63:32] time
//   m_axis    out        tvalid/tready              tdata[0] allowed, [1] new_client,
//                                                   [2] table_full, [18:3] tokens_left
//   apb       in         psel/penable/pwrite/pready 0x0 refill_per_tick, 0x4 burst_tokens
//
// A request scans the table from entry 0 until it hits or has read all n entries
// held, and skips the scan on an empty table: the entries are read one per cycle
// through the single read port of the table RAM. Reset leaves the table empty;
// no clearing pass.
// A finished result waits in the output register while the next request is
// taken; a request finishing before that result is read stalls in write back.
`timescale 1ns / 1ps

module per_client_token_bucket_limiter_core #(
  parameter int unsigned CLIENT_ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ptbl_pkg::IN_W-1:0]  s_axis_tdata,   // client_address, current_time
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ptbl_pkg::OUT_W-1:0] m_axis_tdata,   // allowed, new_client, table_full,
                                                     // tokens_left, zero pad
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ptbl_pkg::*;

  logic [23:0]  refill_q;
  logic [15:0]  burst_q;
  logic         cfg_wr;
  ptbl_cmd_t    dp_cmd;
  ptbl_status_t dp_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_q <= RATE_DEFAULT;
      burst_q  <= BURST_DEFAULT;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_REFILL) begin
        refill_q <= pwdata[23:0];
      end else begin
        burst_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BURST) ? {16'h0000, burst_q} : {8'h00, refill_q};

  ptbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  ptbl_datapath #(
    .CLIENT_ENTRIES (CLIENT_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .rate_i      (refill_q),
    .burst_i     (burst_q),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // result is only loaded when the output register can take it
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> dp_status.out_free)
    else $error("result overwrote a pending result");

  // untracked client passes with no tokens and no new bucket
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |->
      m_axis_tdata[0] && !m_axis_tdata[1] && (m_axis_tdata[18:3] == 16'd0))
    else $error("inconsistent table full result");

  // a fresh bucket always grants the request
  a_new_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && !m_axis_tdata[2])
    else $error("new client not allowed");

endmodule
